FILE: hw/rtl/crext_pkg.sv
package crext_pkg;

  // fixed field widths of the radius and table entries
  localparam int RADIUS_W       = 6;
  localparam int SQ_W           = 2 * RADIUS_W;
  localparam int STEP_W         = $clog2(RADIUS_W);
  localparam int MAX_RADIUS_DEF = 63;

endpackage

FILE: hw/rtl/crext_root.sv
module crext_root (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [crext_pkg::SQ_W-1:0]    x,
  output logic                          done,
  output logic [crext_pkg::RADIUS_W-1:0] root
);
  import crext_pkg::*;

  logic [SQ_W-1:0]     x_r, x_nxt;
  logic [RADIUS_W-1:0] s_r, s_nxt;
  logic [STEP_W-1:0]   bit_r, bit_nxt;
  logic                run_r, run_nxt;
  logic                fin_r, fin_nxt;

  logic [RADIUS_W-1:0] trial;
  logic [SQ_W-1:0]     trial_sq;
  logic [SQ_W-1:0]     s_sq;
  logic [SQ_W-1:0]     rem;
  logic                rnd_up;

  // one result bit per cycle, msb first
  assign trial    = s_r | (RADIUS_W'(1) << bit_r);
  assign trial_sq = SQ_W'(trial) * SQ_W'(trial);

  // remainder test for rounding to nearest
  assign s_sq   = SQ_W'(s_r) * SQ_W'(s_r);
  assign rem    = x_r - s_sq;
  assign rnd_up = rem > SQ_W'(s_r);
  assign root   = s_r + RADIUS_W'(rnd_up);
  assign done   = fin_r;

  // next-state logic
  always_comb begin
    x_nxt   = x_r;
    s_nxt   = s_r;
    bit_nxt = bit_r;
    run_nxt = run_r;
    fin_nxt = 1'b0;
    if (start) begin
      x_nxt   = x;
      s_nxt   = '0;
      bit_nxt = STEP_W'(RADIUS_W - 1);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (trial_sq <= x_r) begin
        s_nxt = trial;
      end
      if (bit_r == '0) begin
        run_nxt = 1'b0;
        fin_nxt = 1'b1;
      end else begin
        bit_nxt = bit_r - STEP_W'(1);
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      fin_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
      fin_r <= fin_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    s_r   <= s_nxt;
    bit_r <= bit_nxt;
  end

endmodule

FILE: hw/rtl/circle_row_extent_table_unit.sv
// Builds the disc half-width table for one radius and streams rows 0..radius.
// Steps: a split search, then a rounded root from the root unit for each lower row, then
// a scan of the table entries for each mirrored row, then the result beats, each held until taken.
// Radius 0 gives its single beat in the cycle after it is taken.
// One radius at a time; a new radius is taken once the last beat has gone out.
// Reset clears the control state only; the table memory keeps its contents.
module circle_row_extent_table_unit #(
  parameter int MAX_RADIUS = crext_pkg::MAX_RADIUS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [crext_pkg::RADIUS_W-1:0] in_radius,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [crext_pkg::RADIUS_W-1:0] out_row_offset,
  output logic [crext_pkg::RADIUS_W-1:0] out_half_width,
  output logic                           out_last
);
  import crext_pkg::*;

  localparam int DEPTH = MAX_RADIUS + 2;
  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b00000000001,
    ST_SPLIT  = 11'b00000000010,
    ST_LSTART = 11'b00000000100,
    ST_LWAIT  = 11'b00000001000,
    ST_M_RDA  = 11'b00000010000,
    ST_M_LDA  = 11'b00000100000,
    ST_M_CMP  = 11'b00001000000,
    ST_M_WR   = 11'b00010000000,
    ST_O_RD   = 11'b00100000000,
    ST_O_LD   = 11'b01000000000,
    ST_O_WAIT = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [IDX_W-1:0]    r_r, r_nxt;
  logic [IDX_W-1:0]    k_r, k_nxt;
  logic [IDX_W-1:0]    split_r, split_nxt;
  logic [IDX_W-1:0]    v_r, v_nxt;
  logic [IDX_W-1:0]    v0_r, v0_nxt;
  logic [IDX_W-1:0]    vm_r, vm_nxt;
  logic [IDX_W-1:0]    ov_r, ov_nxt;
  logic [RADIUS_W-1:0] a_r, a_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [RADIUS_W-1:0] out_row_r, out_row_nxt;
  logic [RADIUS_W-1:0] out_hw_r, out_hw_nxt;
  logic                out_last_r, out_last_nxt;

  // table memory
  logic [RADIUS_W-1:0] ext_mem [DEPTH];
  logic [RADIUS_W-1:0] rdata_r;
  logic [IDX_W-1:0]    raddr;
  logic                we;
  logic [IDX_W-1:0]    waddr;
  logic [RADIUS_W-1:0] wdata;

  // square arithmetic
  logic [RADIUS_W-1:0] rad_sat;
  logic [RADIUS_W-1:0] r6;
  logic [SQ_W-1:0]     rsq;
  logic [RADIUS_W-1:0] kp1;
  logic [SQ_W:0]       kp1_sq2;
  logic [IDX_W-1:0]    vsel;
  logic [RADIUS_W-1:0] v6;
  logic [SQ_W-1:0]     root_x;
  logic                root_start;
  logic                root_done;
  logic [RADIUS_W-1:0] root_val;
  logic [IDX_W-1:0]    v0_inc;

  assign rad_sat = (in_radius > RADIUS_W'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS) : in_radius;
  assign r6      = RADIUS_W'(r_r);
  assign rsq     = SQ_W'(r6) * SQ_W'(r6);
  assign kp1     = RADIUS_W'(k_r) + RADIUS_W'(1);
  assign kp1_sq2 = {SQ_W'(kp1) * SQ_W'(kp1), 1'b0};

  // radicand for the row being started
  assign vsel   = (state_r == ST_LWAIT) ? v_r + IDX_W'(1) : v_r;
  assign v6     = RADIUS_W'(vsel);
  assign root_x = (vsel <= r_r) ? rsq - SQ_W'(v6) * SQ_W'(v6) : '0;

  assign v0_inc = v0_r + IDX_W'(1);

  crext_root u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .x     (root_x),
    .done  (root_done),
    .root  (root_val)
  );

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_row_offset = out_row_r;
  assign out_half_width = out_hw_r;
  assign out_last       = out_last_r;

  // read address per phase
  always_comb begin
    case (state_r)
      ST_M_RDA:  raddr = v0_r;
      ST_M_LDA:  raddr = v0_inc;
      ST_M_CMP:  raddr = v0_r + IDX_W'(2);
      ST_O_WAIT: raddr = ov_r + IDX_W'(1);
      default:   raddr = ov_r;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    r_nxt         = r_r;
    k_nxt         = k_r;
    split_nxt     = split_r;
    v_nxt         = v_r;
    v0_nxt        = v0_r;
    vm_nxt        = vm_r;
    ov_nxt        = ov_r;
    a_nxt         = a_r;
    out_valid_nxt = out_valid_r;
    out_row_nxt   = out_row_r;
    out_hw_nxt    = out_hw_r;
    out_last_nxt  = out_last_r;
    root_start    = 1'b0;
    we            = 1'b0;
    waddr         = v_r;
    wdata         = root_val;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_radius == '0) begin
            out_row_nxt   = '0;
            out_hw_nxt    = '0;
            out_last_nxt  = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_O_WAIT;
          end else begin
            r_nxt     = IDX_W'(rad_sat);
            k_nxt     = '0;
            state_nxt = ST_SPLIT;
          end
        end
      end

      // largest k with 2*k*k <= r*r
      ST_SPLIT: begin
        if (kp1_sq2 <= {1'b0, rsq}) begin
          k_nxt = k_r + IDX_W'(1);
        end else begin
          split_nxt = k_r + IDX_W'(1);
          v_nxt     = '0;
          state_nxt = ST_LSTART;
        end
      end

      ST_LSTART: begin
        root_start = 1'b1;
        state_nxt  = ST_LWAIT;
      end

      // lower rows: rounded root, next row starts on completion
      ST_LWAIT: begin
        if (root_done) begin
          we    = 1'b1;
          v_nxt = v_r + IDX_W'(1);
          if (v_r == split_r) begin
            vm_nxt    = r_r;
            v0_nxt    = '0;
            state_nxt = ST_M_RDA;
          end else begin
            root_start = 1'b1;
          end
        end
      end

      ST_M_RDA: begin
        state_nxt = ST_M_LDA;
      end

      ST_M_LDA: begin
        a_nxt = rdata_r;
        if (v0_r != LAST_IDX) begin
          state_nxt = ST_M_CMP;
        end else begin
          state_nxt = ST_M_WR;
        end
      end

      // skip over a run of equal entries
      ST_M_CMP: begin
        if (rdata_r == a_r) begin
          v0_nxt = v0_inc;
          if (v0_inc == LAST_IDX) begin
            state_nxt = ST_M_WR;
          end
        end else begin
          state_nxt = ST_M_WR;
        end
      end

      ST_M_WR: begin
        we     = 1'b1;
        waddr  = vm_r;
        wdata  = RADIUS_W'(v0_r);
        v0_nxt = (v0_r == LAST_IDX) ? v0_r : v0_inc;
        if (vm_r == split_r) begin
          ov_nxt    = '0;
          state_nxt = ST_O_RD;
        end else begin
          vm_nxt    = vm_r - IDX_W'(1);
          state_nxt = ST_M_RDA;
        end
      end

      ST_O_RD: begin
        state_nxt = ST_O_LD;
      end

      ST_O_LD: begin
        out_row_nxt   = RADIUS_W'(ov_r);
        out_hw_nxt    = rdata_r;
        out_last_nxt  = (ov_r == r_r);
        out_valid_nxt = 1'b1;
        state_nxt     = ST_O_WAIT;
      end

      // hold the beat until taken, fetch the next row meanwhile
      ST_O_WAIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            ov_nxt    = ov_r + IDX_W'(1);
            state_nxt = ST_O_LD;
          end
        end
      end

      default: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // counters and payload
  always_ff @(posedge clk) begin
    r_r        <= r_nxt;
    k_r        <= k_nxt;
    split_r    <= split_nxt;
    v_r        <= v_nxt;
    v0_r       <= v0_nxt;
    vm_r       <= vm_nxt;
    ov_r       <= ov_nxt;
    a_r        <= a_nxt;
    out_row_r  <= out_row_nxt;
    out_hw_r   <= out_hw_nxt;
    out_last_r <= out_last_nxt;
  end

  // table memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      ext_mem[waddr] <= wdata;
    end
    rdata_r <= ext_mem[raddr];
  end

endmodule

FILE: bench/tb_circle_row_extent_table_unit.sv
`timescale 1ns / 1ps

module tb_circle_row_extent_table_unit;
  import crext_pkg::*;

  localparam int MAX_RAD     = MAX_RADIUS_DEF;
  localparam int TABLE_DEPTH = MAX_RAD + 2;
  localparam int PHASE_LEN   = 137;
  localparam int RANDOM_CNT  = 394;
  localparam int DRAIN_CYC   = 64;

  typedef struct packed {
    logic [RADIUS_W-1:0] row_offset;
    logic [RADIUS_W-1:0] half_width;
    logic                last;
  } extent_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [RADIUS_W-1:0] in_radius = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [RADIUS_W-1:0] out_row_offset;
  logic [RADIUS_W-1:0] out_half_width;
  logic                out_last;

  logic [RADIUS_W-1:0] radius_queue[$];
  extent_row_t         extent_rows_due[$];
  logic [RADIUS_W-1:0] extent_mem[TABLE_DEPTH];
  bit                  in_taken;
  int                  radii_taken;
  int                  mismatch_cnt;

  circle_row_extent_table_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_radius      (in_radius),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_row_offset (out_row_offset),
    .out_half_width (out_half_width),
    .out_last       (out_last)
  );

  always #4 clk = ~clk;

  // predict the half-width rows of one disc and queue them
  task automatic build_extent_rows(input logic [RADIUS_W-1:0] radius);
    int          r;
    int          k;
    int          split;
    int          v;
    int          v0;
    int          x;
    int          s;
    extent_row_t row;
    r = radius;
    if (r == 0) begin
      row.row_offset = '0;
      row.half_width = '0;
      row.last       = 1'b1;
      extent_rows_due = {extent_rows_due, row};
    end else begin
      if (r > MAX_RAD) r = MAX_RAD;
      // split row: largest k with 2*k*k <= r*r, plus one
      k = 0;
      while (2 * (k + 1) * (k + 1) <= r * r) k++;
      split = k + 1;
      // lower rows: integer root rounded by remainder test
      for (v = 0; v <= split && v < TABLE_DEPTH; v++) begin
        x = (v <= r) ? r * r - v * v : 0;
        s = 0;
        while ((s + 1) * (s + 1) <= x) s++;
        if (x - s * s > s) s++;
        extent_mem[v] = s[RADIUS_W-1:0];
      end
      // upper rows: mirrored from run lengths of the lower rows
      v0 = 0;
      for (v = r; v >= split; v--) begin
        while (v0 + 1 < TABLE_DEPTH && extent_mem[v0] == extent_mem[v0 + 1]) v0++;
        extent_mem[v] = v0[RADIUS_W-1:0];
        v0++;
        if (v0 >= TABLE_DEPTH) v0 = TABLE_DEPTH - 1;
      end
      for (v = 0; v <= r; v++) begin
        row.row_offset = v[RADIUS_W-1:0];
        row.half_width = extent_mem[v];
        row.last       = (v == r);
        extent_rows_due = {extent_rows_due, row};
      end
    end
  endtask

  // input driver, one radius per beat
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (radius_queue.size() != 0 &&
          $urandom_range(99) >= ((radii_taken < PHASE_LEN) ? 13 :
                                 (radii_taken < 2 * PHASE_LEN) ? 51 : 0)) begin
        in_valid  <= 1'b1;
        in_radius <= radius_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result backpressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= ((radii_taken < PHASE_LEN) ? 51 :
                                         (radii_taken < 2 * PHASE_LEN) ? 13 : 0));
  end

  // monitor: predict on input beats, check result beats
  always @(posedge clk) begin
    extent_row_t want;
    in_taken = 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        radii_taken++;
        build_extent_rows(in_radius);
      end
      if (out_valid && out_ready) begin
        if (extent_rows_due.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected beat row_offset=%0d half_width=%0d last=%0b",
                   $time, out_row_offset, out_half_width, out_last);
        end else begin
          want = extent_rows_due.pop_front();
          if (out_row_offset !== want.row_offset) begin
            mismatch_cnt++;
            $display("%0t: row_offset expected %0d actual %0d",
                     $time, want.row_offset, out_row_offset);
          end
          if (out_half_width !== want.half_width) begin
            mismatch_cnt++;
            $display("%0t: half_width at row %0d expected %0d actual %0d",
                     $time, want.row_offset, want.half_width, out_half_width);
          end
          if (out_last !== want.last) begin
            mismatch_cnt++;
            $display("%0t: last at row %0d expected %0b actual %0b",
                     $time, want.row_offset, want.last, out_last);
          end
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    int pick;
    // directed: extremes, small and boundary radii, zero radius
    radius_queue = '{6'd1, 6'd63, 6'd0, 6'd2, 6'd3, 6'd4, 6'd5, 6'd7, 6'd8, 6'd15,
                     6'd16, 6'd31, 6'd32, 6'd42, 6'd62, 6'd0, 6'd1, 6'd63};
    // random: mostly full range, some small radii, some extremes
    repeat (RANDOM_CNT) begin
      pick = $urandom_range(99);
      if (pick < 55)
        radius_queue = {radius_queue, 6'($urandom_range(63, 1))};
      else if (pick < 85)
        radius_queue = {radius_queue, 6'($urandom_range(8, 1))};
      else
        radius_queue = {radius_queue, (($urandom_range(1) != 0) ? 6'd63 : 6'd1)};
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (radius_queue.size() != 0 || in_valid) @(posedge clk);
    while (extent_rows_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
